### src/vspid_pkg.sv
// vspid_pkg: shared constants for the visual servo pid block
// request kinds, register indexes, gain layout and fixed-point shifts
// no dependencies
package vspid_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_YAW_GAINS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VERT_GAINS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LAT_GAINS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_YAW    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_VERT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LAT_TMO    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd7;

    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_TARGET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_AVOID  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    localparam int GAIN_W  = 16;
    localparam int GAINS_W = 3 * GAIN_W;
    localparam int LIM_W   = 15;
    localparam int TMO_W   = 16;
    localparam int AERR_W  = 16;
    localparam int ERR_W   = 17;
    localparam int OUT_W   = 16;
    localparam int OUT_TW  = 3 * OUT_W;

    localparam logic [GAINS_W-1:0] YAW_GAINS_RST  = 48'd846109016130;
    localparam logic [GAINS_W-1:0] VERT_GAINS_RST = 48'd1125281890370;
    localparam logic [GAINS_W-1:0] LAT_GAINS_RST  = 48'd140737531287962;
    localparam logic [LIM_W-1:0]   MAX_YAW_RST    = 15'd2560;
    localparam logic [LIM_W-1:0]   MAX_VERT_RST   = 15'd5120;
    localparam logic [TMO_W-1:0]   LAT_TMO_RST    = 16'd512;
    localparam int CENTER_X_RST = 480;
    localparam int CENTER_Y_RST = 360;

    localparam int P_SHIFT_PIX = 8;
    localparam int I_SHIFT_PIX = 18;
    localparam int P_SHIFT_LAT = 10;
    localparam int I_SHIFT_LAT = 20;
    localparam int LAT_LIMIT   = 16384;

endpackage

### src/visual_servo_pid_with_lateral_avoid.sv
// visual_servo_pid_with_lateral_avoid: yaw, vertical and lateral pid loops
// with one bit-serial shift-add multiplier and one bit-serial restoring divider
// depends on vspid_pkg
//
// channel   dir  handshake                 contents
// s_axis    in   tvalid/tready             tuser req_type, tdata pixels/error/time
// m_axis    out  tvalid/tready             tdata yaw, vertical, lateral commands
// cfg       in   wr_en, no wait            register index and write data
//
// in each pid loop the multiplier works one bit of its unsigned operand per
// cycle, the divider one quotient bit per cycle. a target transaction runs
// two loops, an avoidance transaction one, a tick none; one transaction is
// worked on at a time.
// reset is synchronous, active low. a finished command sits in an output
// register, so the next input is taken while it waits; a second command
// stalls until the first has been taken.
module visual_servo_pid_with_lateral_avoid #(
    parameter int PIXEL_BITS    = 10,
    parameter int TIME_BITS     = 32,
    parameter int INTEGRAL_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [vspid_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [vspid_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pixel_x, pixel_y, avoid_error, timestamp, zero fill
    input  logic [((2*PIXEL_BITS+vspid_pkg::AERR_W+TIME_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // req_type
    input  logic [vspid_pkg::REQ_W-1:0]         i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // yaw_rate, vertical_speed, lateral_speed
    output logic [vspid_pkg::OUT_TW-1:0]        o_m_axis_tdata
);
    import vspid_pkg::*;

    localparam int AW      = INTEGRAL_BITS;
    localparam int BW      = TIME_BITS;
    localparam int PW      = AW + BW;
    localparam int NW      = GAIN_W + ERR_W;
    localparam int CNT_MAX = (BW > NW) ? BW : NW;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int PX_LO   = 0;
    localparam int PY_LO   = PIXEL_BITS;
    localparam int AE_LO   = 2 * PIXEL_BITS;
    localparam int TS_LO   = AE_LO + AERR_W;
    localparam logic signed [PW:0] IMAX = {{(PW-AW+2){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [PW:0] IMIN = ~IMAX;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_LOAD, S_MUL, S_POST, S_DIV, S_FIN, S_CLAMP, S_EMIT
    } t_state;
    typedef enum logic [1:0] {L_YAW, L_VERT, L_LAT} t_loop;
    typedef enum logic [1:0] {ST_INT, ST_P, ST_I, ST_D} t_step;

    t_state r_state;
    t_loop  r_loop;
    t_step  r_step;

    // configuration
    logic [GAINS_W-1:0]    r_yaw_gains, r_vert_gains, r_lat_gains;
    logic [LIM_W-1:0]      r_max_yaw, r_max_vert;
    logic [TMO_W-1:0]      r_lat_tmo;
    logic [PIXEL_BITS-1:0] r_center_x, r_center_y;

    // loop state
    logic signed [AW-1:0]         r_yaw_int, r_vert_int, r_lat_int;
    logic signed [PIXEL_BITS:0]   r_last_yaw_err, r_last_vert_err;
    logic signed [AERR_W-1:0]     r_last_lat_err;
    logic [BW-1:0]                r_last_upd, r_last_avoid;
    logic signed [OUT_W-1:0]      r_lat_out;

    // transaction payload
    logic [REQ_W-1:0]         r_type;
    logic [PIXEL_BITS-1:0]    r_px, r_py;
    logic signed [AERR_W-1:0] r_aerr;
    logic [BW-1:0]            r_ts;
    logic [BW-1:0]            r_dt;

    // serial arithmetic
    logic signed [PW-1:0] r_acc, r_mshift, r_sum;
    logic [BW-1:0]        r_mb;
    logic [CW-1:0]        r_cnt;
    logic [NW-1:0]        r_dq;
    logic [BW-1:0]        r_rem;
    logic                 r_nneg;

    logic signed [OUT_W-1:0]  r_yaw_cmd, r_vert_cmd;
    logic                     r_m_valid;
    logic [OUT_TW-1:0]        r_m_data;

    logic [GAINS_W-1:0]       w_gains;
    logic [GAIN_W-1:0]        w_kp, w_ki, w_kd;
    logic signed [ERR_W-1:0]  w_ex, w_ey, w_err, w_prev, w_diff, w_dd;
    logic signed [AW-1:0]     w_integ, w_isat;
    logic signed [PW:0]       w_isum;
    logic [BW-1:0]            w_dtu, w_el;
    logic                     w_dt_ok, w_tmo;
    logic [BW:0]              w_trial, w_tsub;
    logic                     w_qbit;
    logic signed [NW-1:0]     w_n;
    logic [NW-1:0]            w_nmag;
    logic signed [NW:0]       w_dval;
    logic signed [PW-1:0]     w_pterm, w_iterm, w_lim, w_total;
    logic signed [OUT_W-1:0]  w_clamped;

    always_comb begin
        w_ex = $signed(ERR_W'(r_px)) - $signed(ERR_W'(r_center_x));
        w_ey = $signed(ERR_W'(r_py)) - $signed(ERR_W'(r_center_y));
        unique case (r_loop)
            L_YAW: begin
                w_gains = r_yaw_gains;
                w_err   = w_ex;
                w_prev  = ERR_W'(r_last_yaw_err);
                w_integ = r_yaw_int;
                w_lim   = PW'($signed({1'b0, r_max_yaw}));
            end
            L_VERT: begin
                w_gains = r_vert_gains;
                w_err   = w_ey;
                w_prev  = ERR_W'(r_last_vert_err);
                w_integ = r_vert_int;
                w_lim   = PW'($signed({1'b0, r_max_vert}));
            end
            default: begin
                w_gains = r_lat_gains;
                w_err   = ERR_W'(r_aerr);
                w_prev  = ERR_W'(r_last_lat_err);
                w_integ = r_lat_int;
                w_lim   = PW'(LAT_LIMIT);
            end
        endcase
        w_kp   = w_gains[3*GAIN_W-1:2*GAIN_W];
        w_ki   = w_gains[2*GAIN_W-1:GAIN_W];
        w_kd   = w_gains[GAIN_W-1:0];
        w_diff = w_err - w_prev;
        // pixel loops scale the derivative by four
        w_dd   = (r_loop == L_LAT) ? w_diff : (w_diff <<< 2);

        w_isum = (PW+1)'(w_integ) + (PW+1)'(r_acc);
        if (w_isum > IMAX) begin
            w_isat = IMAX[AW-1:0];
        end else if (w_isum < IMIN) begin
            w_isat = IMIN[AW-1:0];
        end else begin
            w_isat = w_isum[AW-1:0];
        end

        w_dtu   = r_ts - r_last_upd;
        w_el    = r_ts - r_last_avoid;
        w_dt_ok = (w_dtu != '0) && !w_dtu[BW-1];
        w_tmo   = !w_el[BW-1] && (w_el > BW'(r_lat_tmo)) && (r_lat_out != '0);

        w_trial = {r_rem, r_dq[NW-1]};
        w_tsub  = w_trial - {1'b0, r_dt};
        w_qbit  = !w_tsub[BW];

        w_n    = r_acc[NW-1:0];
        w_nmag = w_n[NW-1] ? NW'(-w_n) : NW'(w_n);
        // floor division: round a negative quotient down when inexact
        w_dval = r_nneg ? -($signed({1'b0, r_dq}) + $signed((NW+1)'(r_rem != '0)))
                        : $signed({1'b0, r_dq});

        w_pterm = (r_loop == L_LAT) ? (r_acc >>> P_SHIFT_LAT) : (r_acc >>> P_SHIFT_PIX);
        w_iterm = (r_loop == L_LAT) ? (r_acc >>> I_SHIFT_LAT) : (r_acc >>> I_SHIFT_PIX);

        w_total = r_sum;
        if (r_sum > w_lim) begin
            w_total = w_lim;
        end else if (r_sum < -w_lim) begin
            w_total = -w_lim;
        end
        w_clamped = w_total[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_loop          <= L_YAW;
            r_step          <= ST_INT;
            r_m_valid       <= 1'b0;
            r_yaw_gains     <= YAW_GAINS_RST;
            r_vert_gains    <= VERT_GAINS_RST;
            r_lat_gains     <= LAT_GAINS_RST;
            r_max_yaw       <= MAX_YAW_RST;
            r_max_vert      <= MAX_VERT_RST;
            r_lat_tmo       <= LAT_TMO_RST;
            r_center_x      <= PIXEL_BITS'(CENTER_X_RST);
            r_center_y      <= PIXEL_BITS'(CENTER_Y_RST);
            r_yaw_int       <= '0;
            r_vert_int      <= '0;
            r_lat_int       <= '0;
            r_last_yaw_err  <= '0;
            r_last_vert_err <= '0;
            r_last_lat_err  <= '0;
            r_last_upd      <= '0;
            r_last_avoid    <= '0;
            r_lat_out       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    REG_YAW_GAINS:  r_yaw_gains  <= i_cfg_wr_data[GAINS_W-1:0];
                    REG_VERT_GAINS: r_vert_gains <= i_cfg_wr_data[GAINS_W-1:0];
                    REG_LAT_GAINS:  r_lat_gains  <= i_cfg_wr_data[GAINS_W-1:0];
                    REG_MAX_YAW:    r_max_yaw    <= i_cfg_wr_data[LIM_W-1:0];
                    REG_MAX_VERT:   r_max_vert   <= i_cfg_wr_data[LIM_W-1:0];
                    REG_LAT_TMO:    r_lat_tmo    <= i_cfg_wr_data[TMO_W-1:0];
                    REG_CENTER_X:   r_center_x   <= i_cfg_wr_data[PIXEL_BITS-1:0];
                    REG_CENTER_Y:   r_center_y   <= i_cfg_wr_data[PIXEL_BITS-1:0];
                    default: ;
                endcase
            end

            // the emit state refills the output register itself
            if (r_m_valid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_type  <= i_s_axis_tuser;
                        r_px    <= i_s_axis_tdata[PX_LO +: PIXEL_BITS];
                        r_py    <= i_s_axis_tdata[PY_LO +: PIXEL_BITS];
                        r_aerr  <= i_s_axis_tdata[AE_LO +: AERR_W];
                        r_ts    <= i_s_axis_tdata[TS_LO +: BW];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_dt    <= w_dtu;
                    r_state <= S_IDLE;
                    unique case (r_type)
                        REQ_TARGET: begin
                            if (w_dt_ok) begin
                                r_loop  <= L_YAW;
                                r_state <= S_LOAD;
                            end
                        end
                        REQ_AVOID: begin
                            if (w_dt_ok) begin
                                r_loop  <= L_LAT;
                                r_state <= S_LOAD;
                            end
                        end
                        REQ_TICK: begin
                            if (w_tmo) begin
                                r_lat_out      <= '0;
                                r_lat_int      <= '0;
                                r_last_lat_err <= '0;
                                r_last_upd     <= r_ts;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LOAD: begin
                    // integral term: err * dt
                    r_acc    <= '0;
                    r_mshift <= PW'(w_err);
                    r_mb     <= r_dt;
                    r_cnt    <= CW'(BW);
                    r_step   <= ST_INT;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_mshift;
                    end
                    r_mshift <= r_mshift <<< 1;
                    r_mb     <= r_mb >> 1;
                    r_cnt    <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_acc   <= '0;
                    r_state <= S_MUL;
                    unique case (r_step)
                        ST_INT: begin
                            unique case (r_loop)
                                L_YAW:   r_yaw_int  <= w_isat;
                                L_VERT:  r_vert_int <= w_isat;
                                default: r_lat_int  <= w_isat;
                            endcase
                            r_mshift <= PW'(w_err);
                            r_mb     <= BW'(w_kp);
                            r_cnt    <= CW'(GAIN_W);
                            r_step   <= ST_P;
                        end
                        ST_P: begin
                            r_sum    <= w_pterm;
                            r_mshift <= PW'(w_integ);
                            r_mb     <= BW'(w_ki);
                            r_cnt    <= CW'(GAIN_W);
                            r_step   <= ST_I;
                        end
                        ST_I: begin
                            r_sum    <= r_sum + w_iterm;
                            r_mshift <= PW'(w_dd);
                            r_mb     <= BW'(w_kd);
                            r_cnt    <= CW'(GAIN_W);
                            r_step   <= ST_D;
                        end
                        default: begin
                            r_nneg  <= w_n[NW-1];
                            r_dq    <= w_nmag;
                            r_rem   <= '0;
                            r_cnt   <= CW'(NW);
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_DIV: begin
                    r_rem <= w_qbit ? w_tsub[BW-1:0] : w_trial[BW-1:0];
                    r_dq  <= {r_dq[NW-2:0], w_qbit};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_sum   <= r_sum + PW'(w_dval);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    unique case (r_loop)
                        L_YAW: begin
                            r_yaw_cmd      <= w_clamped;
                            r_last_yaw_err <= w_err[PIXEL_BITS:0];
                            r_loop         <= L_VERT;
                            r_state        <= S_LOAD;
                        end
                        L_VERT: begin
                            r_vert_cmd      <= w_clamped;
                            r_last_vert_err <= w_err[PIXEL_BITS:0];
                            r_last_upd      <= r_ts;
                            r_state         <= S_EMIT;
                        end
                        default: begin
                            r_lat_out      <= w_clamped;
                            r_last_lat_err <= w_err[AERR_W-1:0];
                            r_last_avoid   <= r_ts;
                            r_last_upd     <= r_ts;
                            r_state        <= S_IDLE;
                        end
                    endcase
                end
                S_EMIT: begin
                    // wait for the previous command to leave the output register
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_data  <= {r_lat_out, r_vert_cmd, r_yaw_cmd};
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule
